// ----- design/clos_pkg.sv -----
// ----------------------------------------------------------------------------
// clos_pkg: shared definitions for the circular overwrite stack
// Operation and status codes and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package clos_pkg;

    // Fixed field widths of the input and result items.
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PENDING_W = 10;

    // Operation codes carried by the operation field.
    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Status codes carried by the status field.
    typedef enum logic [0:0] {
        ST_DONE  = 1'b0,
        ST_EMPTY = 1'b1
    } status_t;

endpackage

// ----- design/circular_lifo_overwrite_store.sv -----
// ----------------------------------------------------------------------------
// circular_lifo_overwrite_store: ring stack that drops its oldest entry
// A DEPTH-word ring holds up to DEPTH-1 words. Pushes overwrite the oldest
// word when full; pops return the newest word first.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, operation, data_in) takes one
//   push or pop per item. The result channel (out_valid, out_stall, status,
//   data_out, overwrote, pending) returns exactly one item per operation,
//   in order.
//   out_valid rises once the read stage moves into the result register; the
//   storage RAM is read at the acceptance edge. Throughput is one item per
//   cycle while the receiver does not stall; the pointers update at the
//   acceptance edge, so a pop right after a push reads the word just written.
//   The RAM has one write port and one read port, and each operation uses
//   at most one of them.
//   When the receiver stalls, the result register holds its item and the
//   read stage behind it holds one more; after that in_stall rises until
//   the result register is taken.
//   Reset clears the pointers, the count and the valid flags; the RAM is
//   not cleared, since no word is read before it has been written.
// ----------------------------------------------------------------------------
module circular_lifo_overwrite_store
    import clos_pkg::*;
#(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [WORD_W-1:0]    data_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output logic [WORD_W-1:0]    data_out,
    output logic                 overwrote,
    output logic [PENDING_W-1:0] pending
);

    localparam int unsigned PTR_W   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int unsigned STORE_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    // Storage RAM and its registered read data.
    logic [STORE_W-1:0] mem [DEPTH];
    logic [STORE_W-1:0] rdata_reg;

    // Ring pointers and entry count.
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] count_reg, count_next;

    // Read stage: the item whose RAM read is in flight.
    logic                 s1_valid_reg;
    logic                 s1_status_reg;
    logic                 s1_popped_reg;
    logic                 s1_over_reg;
    logic [PENDING_W-1:0] s1_pending_reg;

    // Result register.
    logic                 out_valid_reg;
    logic                 status_reg;
    logic [WORD_W-1:0]    data_out_reg;
    logic                 overwrote_reg;
    logic [PENDING_W-1:0] pending_reg;

    logic                 accept;
    logic                 is_push;
    logic                 empty;
    logic                 wr_en;
    logic                 rd_en;
    logic                 over_now;
    logic                 s1_adv;
    logic [PTR_W-1:0]     head_inc;
    logic [PTR_W-1:0]     head_dec;
    logic [PTR_W-1:0]     tail_inc;
    logic [PENDING_W+PTR_W-1:0] pending_ext;
    logic [WORD_W+STORE_W-1:0]  rdata_ext;

    // Handshake control: the read stage moves on when the result register
    // is free or being emptied.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;
    assign is_push  = (operation == OP_PUSH);
    assign empty    = (head_reg == tail_reg);

    // Ring arithmetic for any depth, not only powers of two.
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - PTR_W'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + PTR_W'(1);

    // Next pointer and count values for the accepted operation.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        over_now   = 1'b0;
        if (accept)
        begin
            if (is_push)
            begin
                wr_en     = 1'b1;
                head_next = head_inc;
                if (head_inc == tail_reg)
                begin
                    tail_next = tail_inc;
                    over_now  = 1'b1;
                end
                else
                begin
                    count_next = count_reg + PTR_W'(1);
                end
            end
            else if (!empty)
            begin
                rd_en      = 1'b1;
                head_next  = head_dec;
                count_next = count_reg - PTR_W'(1);
            end
        end
    end

    // The reported count is taken modulo 2^PENDING_W.
    assign pending_ext = {{PENDING_W{1'b0}}, count_next};
    assign rdata_ext   = {{WORD_W{1'b0}}, rdata_reg};

    // Storage RAM: one write port at head, one read port one below head.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[head_reg] <= data_in[STORE_W-1:0];
        end
        if (rd_en)
        begin
            rdata_reg <= mem[head_dec];
        end
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Valid flags of the read stage and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the read stage and the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg  <= (!is_push && empty) ? ST_EMPTY : ST_DONE;
            s1_popped_reg  <= rd_en;
            s1_over_reg    <= over_now;
            s1_pending_reg <= pending_ext[PENDING_W-1:0];
        end
        if (s1_adv)
        begin
            status_reg    <= s1_status_reg;
            data_out_reg  <= s1_popped_reg ? rdata_ext[WORD_W-1:0] : '0;
            overwrote_reg <= s1_over_reg;
            pending_reg   <= s1_pending_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign overwrote = overwrote_reg;
    assign pending   = pending_reg;

endmodule

// ----- design/clos_checker.sv -----
// ----------------------------------------------------------------------------
// clos_checker: port-level checks for the circular overwrite stack
// Watches the result channel and checks the relations between its fields.
// ----------------------------------------------------------------------------
module clos_checker
    import clos_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 status,
    input logic [WORD_W-1:0]    data_out,
    input logic                 overwrote,
    input logic [PENDING_W-1:0] pending
);

    logic                 seen_reg;
    logic [PENDING_W-1:0] last_pending_reg;
    logic                 out_take;

    assign out_take = out_valid && !out_stall;

    // Remember the count of the last delivered item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= 1'b0;
            last_pending_reg <= '0;
        end
        else if (out_take)
        begin
            seen_reg         <= 1'b1;
            last_pending_reg <= pending;
        end
    end

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(pending)
            && $stable(status) && $stable(overwrote))
        else $error("stalled result item changed");

    // An empty pop returns no word, drops nothing and reports zero entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |->
            (data_out == '0) && !overwrote && (pending == '0))
        else $error("empty pop result is inconsistent");

    // Each operation moves the count by at most one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg |->
            (pending == last_pending_reg)
            || (pending == last_pending_reg + PENDING_W'(1))
            || (pending == last_pending_reg - PENDING_W'(1)))
        else $error("count moved by more than one entry");

    // An overwrite leaves the count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg && overwrote |-> pending == last_pending_reg)
        else $error("overwrite changed the count");

endmodule

bind circular_lifo_overwrite_store clos_checker u_clos_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out),
    .overwrote (overwrote),
    .pending   (pending)
);

// ----- tb/clos_stack_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clos_stack_checker: result predictor and scoreboard for the overwrite stack
// Watches both channels of the circular stack, keeps its own copy of the
// ring, pointers and count, and compares every result item with the oldest
// predicted reply, field by field. Failures are counted for the top level.
// ----------------------------------------------------------------------------
module clos_stack_checker
    import clos_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 operation,
    input  logic [WORD_W-1:0]    data_in,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 status,
    input  logic [WORD_W-1:0]    data_out,
    input  logic                 overwrote,
    input  logic [PENDING_W-1:0] pending,
    output int                   mismatch_count,
    output int                   replies_owed,
    output int                   result_count,
    output int                   overwrite_count,
    output int                   empty_pop_count
);

    localparam int unsigned RING_DEPTH = 1024;
    localparam int unsigned PTR_W      = $clog2(RING_DEPTH);

    // One predicted result item.
    typedef struct packed {
        status_t              st;
        logic [WORD_W-1:0]    word;
        logic                 over;
        logic [PENDING_W-1:0] held;
    } stack_reply_t;

    // Shadow copy of the ring and its pointers.
    logic [WORD_W-1:0]    ring_words [RING_DEPTH];
    logic [PTR_W-1:0]     head_idx;
    logic [PTR_W-1:0]     tail_idx;
    logic [PENDING_W-1:0] held_words;
    stack_reply_t         stack_replies_q [$];

    initial
    begin
        head_idx        = '0;
        tail_idx        = '0;
        held_words      = '0;
        mismatch_count  = 0;
        replies_owed    = 0;
        result_count    = 0;
        overwrite_count = 0;
        empty_pop_count = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Applies one push or pop to the shadow stack and returns its reply.
    task automatic step_stack(input op_t op, input logic [WORD_W-1:0] word,
                              output stack_reply_t reply);
        reply = '{st: ST_DONE, word: '0, over: 1'b0, held: '0};
        if (op == OP_PUSH)
        begin
            ring_words[head_idx] = word;
            head_idx = head_idx + 1'b1;
            // Head caught up with tail: the oldest word is dropped.
            if (head_idx == tail_idx)
            begin
                tail_idx   = tail_idx + 1'b1;
                reply.over = 1'b1;
            end
            else
            begin
                held_words = held_words + 1'b1;
            end
        end
        else if (head_idx == tail_idx)
        begin
            reply.st = ST_EMPTY;
        end
        else
        begin
            head_idx   = head_idx - 1'b1;
            reply.word = ring_words[head_idx];
            held_words = held_words - 1'b1;
        end
        reply.held = held_words;
    endtask

    // Check the result taken at this edge, then predict the item accepted.
    always @(posedge clk)
    begin
        stack_reply_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (stack_replies_q.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", data_out, '0);
                end
                else
                begin
                    want = stack_replies_q.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", WORD_W'(status), WORD_W'(want.st));
                    if (data_out !== want.word)
                        report_mismatch("data_out", data_out, want.word);
                    if (overwrote !== want.over)
                        report_mismatch("overwrote", WORD_W'(overwrote), WORD_W'(want.over));
                    if (pending !== want.held)
                        report_mismatch("pending", WORD_W'(pending), WORD_W'(want.held));
                    if (want.over)
                        overwrite_count++;
                    if (want.st == ST_EMPTY)
                        empty_pop_count++;
                end
            end
            if (in_valid && !in_stall)
            begin
                step_stack(op_t'(operation), data_in, want);
                stack_replies_q.push_back(want);
            end
            replies_owed <= stack_replies_q.size();
        end
    end

endmodule

// ----- tb/tb_circular_lifo_overwrite_store.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_lifo_overwrite_store: stimulus and verdict for the overwrite stack
// Drives pushes and pops with random gaps and output stalls, including a long
// output hold-off, a fill past capacity with wrap-around and pops back from it.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_circular_lifo_overwrite_store;
    import clos_pkg::*;

    localparam int HOLD_CYCLES = 60;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 operation = 1'b0;
    logic [WORD_W-1:0]    data_in   = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 status;
    logic [WORD_W-1:0]    data_out;
    logic                 overwrote;
    logic [PENDING_W-1:0] pending;

    int   mismatch_count;
    int   replies_owed;
    int   result_count;
    int   overwrite_count;
    int   empty_pop_count;
    int   send_idle_pct = 32;
    int   recv_idle_pct = 50;
    logic hold_toggle   = 1'b0;

    always #5 clk = ~clk;

    circular_lifo_overwrite_store u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .overwrote (overwrote),
        .pending   (pending)
    );

    clos_stack_checker u_stack_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .data_in         (data_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .data_out        (data_out),
        .overwrote       (overwrote),
        .pending         (pending),
        .mismatch_count  (mismatch_count),
        .replies_owed    (replies_owed),
        .result_count    (result_count),
        .overwrite_count (overwrite_count),
        .empty_pop_count (empty_pop_count)
    );

    // Word with the all-zero and all-one patterns mixed in.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item after a random gap and waits until it is accepted.
    task automatic send_op(input op_t op, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_in   <= word;
        do @(posedge clk); while (in_stall);
    endtask

    // Pauses the input until every outstanding result has come back.
    task automatic wait_all_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
    endtask

    // A run of one operation, used to fill and to drain the ring.
    task automatic run_same_op(input op_t op, input int count);
        for (int i = 0; i < count; i++)
            send_op(op, random_word());
    endtask

    // Mostly push bursts followed by pop bursts, with some single random items.
    task automatic run_mixed(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                burst = $urandom_range(12, 1);
                run_same_op(OP_PUSH, burst);
                sent += burst;
                burst = $urandom_range(14, 1);
                run_same_op(OP_POP, burst);
                sent += burst;
            end
            else
            begin
                send_op(op_t'($urandom_range(1)), random_word());
                sent++;
            end
        end
    endtask

    // Output side: random stalls, plus a long hold-off on each request.
    initial
    begin
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Main stimulus sequence and verdict.
    initial
    begin
        int guard;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: empty pops, extreme words and last-in-first-out order.
        send_op(OP_POP, '1);
        send_op(OP_PUSH, '0);
        send_op(OP_PUSH, '1);
        send_op(OP_PUSH, 32'hA5A5_A5A5);
        send_op(OP_PUSH, 32'h5A5A_5A5A);
        run_same_op(OP_POP, 4);
        send_op(OP_POP, '0);
        send_op(OP_PUSH, 32'h0000_0001);
        send_op(OP_POP, '1);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        run_same_op(OP_POP, 3);
        wait_all_replies();

        // Sender idles less than the receiver; one long hold-off fills the pipeline.
        run_mixed(30);
        hold_toggle <= ~hold_toggle;
        run_mixed(10);
        run_mixed(20);
        wait_all_replies();

        // Roles swapped: first half of a fill past capacity.
        send_idle_pct  = 50;
        recv_idle_pct <= 32;
        run_same_op(OP_PUSH, 515);
        wait_all_replies();

        // No idling: finish the fill so the oldest entries are dropped, then pop back.
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        hold_toggle   <= ~hold_toggle;
        run_same_op(OP_PUSH, 515);
        run_same_op(OP_POP, 40);

        // Let the last results come out, with a bound.
        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (replies_owed != 0 && guard < 20000);
        repeat (8) @(posedge clk);

        if (replies_owed != 0)
            $display("%0d result items never arrived", replies_owed);
        $display("Checked %0d results: %0d pushes dropped the oldest entry, %0d pops found it empty.",
                 result_count, overwrite_count, empty_pop_count);
        $display("Ring was filled past capacity, wrapped, popped back, and held off for %0d cycles.",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && replies_owed == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
